@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SKEK_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
`define SKEK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define SKEK_ASSERT_IMPL(label, ante, cons)
`define SKEK_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/skek_pkg.sv @@
// Shared types and constants of the squared exponential kernel block
package skek_pkg;

  localparam int COORD_WIDTH_DEF     = 16;
  localparam int EXP_TABLE_DEPTH_DEF = 256;
  localparam int MAX_DIM_DEF         = 64;
  localparam int QUEUE_DEPTH         = 4;

  localparam int ACC_W        = 40;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 24;
  localparam int KV_W         = 32;
  localparam int POS_SHIFT    = 22;
  localparam int TAYLOR_TERMS = 24;
  localparam int DIST_RANGE   = 64;

  localparam logic [ACC_W-1:0]      ACC_MAX    = '1;
  localparam logic [CFG_DATA_W-1:0] ILSQ_RESET = 24'h01_0000;
  localparam logic [CFG_DATA_W-1:0] SF2_RESET  = 24'h01_0000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_INV_LSQ = 2'd1,
    CFG_SIG_VAR = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_COV    = 2'd0,
    MODE_DLEN   = 2'd1,
    MODE_DSCALE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [ACC_W-1:0] d2;
    logic             ovf;
  } job_t;

endpackage

@@ sv/skek_front.sv @@
// Front end: accepts coordinate pairs, takes the absolute difference, marks pair close
module skek_front #(
  parameter int COORD_WIDTH = skek_pkg::COORD_WIDTH_DEF,
  parameter int MAX_DIM     = skek_pkg::MAX_DIM_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [COORD_WIDTH-1:0] first_coord,
  input  logic [COORD_WIDTH-1:0] second_coord,
  input  logic                   in_tlast,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [COORD_WIDTH:0]   q_wdata
);

  localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 close;
  logic [COORD_WIDTH:0] diff;
  logic [COORD_WIDTH:0] mag;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    diff    = {first_coord[COORD_WIDTH-1], first_coord}
            - {second_coord[COORD_WIDTH-1], second_coord};
    mag     = diff[COORD_WIDTH] ? ((COORD_WIDTH+1)'(0) - diff) : diff;
    close   = in_tlast || (cnt_r == CNT_W'(MAX_DIM - 1));
    cnt_nxt = close ? '0 : cnt_r + 1'b1;
    q_wdata = {close, mag[COORD_WIDTH-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_push) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ sv/skek_fifo.sv @@
// Short queue between the front end and the accumulate pipeline
module skek_fifo #(
  parameter int W     = skek_pkg::COORD_WIDTH_DEF + 1,
  parameter int DEPTH = skek_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign full   = (count_r == CNT_W'(DEPTH));
  assign valid  = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ sv/skek_back.sv @@
// Square, scale and saturating accumulate pipeline; hands closed pairs to the finish unit
module skek_back #(
  parameter int COORD_WIDTH = skek_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  logic [COORD_WIDTH:0]                q_data,
  output logic                                q_pop,
  input  logic [skek_pkg::CFG_DATA_W-1:0]     ilsq,
  output logic                                job_valid,
  output skek_pkg::job_t                      job,
  input  logic                                job_ready
);

  localparam int SQ_W   = 2 * COORD_WIDTH;
  localparam int PROD_W = SQ_W + skek_pkg::CFG_DATA_W;
  localparam int EXT_W  = (PROD_W > 57) ? PROD_W : 57;
  localparam int ACC_W  = skek_pkg::ACC_W;

  logic              v1_r;
  logic              c1_r;
  logic [SQ_W-1:0]   sq1_r;
  logic              v2_r;
  logic              c2_r;
  logic [PROD_W-1:0] prod2_r;
  logic [ACC_W-1:0]  acc_r;
  logic              ovf_r;

  logic              advance;
  logic [EXT_W-1:0]  prod_ext;
  logic [ACC_W-1:0]  term;
  logic              term_ovf;
  logic [ACC_W:0]    sum;
  logic              sat;
  logic [ACC_W-1:0]  acc_nxt;
  logic              ovf_nxt;

  assign advance   = !(v2_r && c2_r && !job_ready);
  assign q_pop     = advance && q_valid;
  assign job_valid = v2_r && c2_r;

  always_comb begin
    prod_ext = EXT_W'(prod2_r);
    term     = prod_ext[55:16];
    term_ovf = |prod_ext[EXT_W-1:56];
    sum      = {1'b0, acc_r} + {1'b0, term};
    sat      = term_ovf || sum[ACC_W];
    acc_nxt  = sat ? skek_pkg::ACC_MAX : sum[ACC_W-1:0];
    ovf_nxt  = ovf_r || sat;
    job.d2   = acc_nxt;
    job.ovf  = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c1_r    <= q_data[COORD_WIDTH];
      sq1_r   <= SQ_W'(q_data[COORD_WIDTH-1:0]) * SQ_W'(q_data[COORD_WIDTH-1:0]);
      c2_r    <= c1_r;
      prod2_r <= PROD_W'(sq1_r) * PROD_W'(ilsq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      acc_r <= '0;
      ovf_r <= 1'b0;
    end else if (advance) begin
      v1_r <= q_valid;
      v2_r <= v1_r;
      if (v2_r) begin
        if (c2_r) begin
          acc_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          acc_r <= acc_nxt;
          ovf_r <= ovf_nxt;
        end
      end
    end
  end

endmodule

@@ sv/skek_finish.sv @@
// Finish unit: exp table lookup with interpolation, output scaling and result register
module skek_finish #(
  parameter int EXP_TABLE_DEPTH = skek_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            job_valid,
  input  skek_pkg::job_t                  job,
  output logic                            job_ready,
  input  logic [1:0]                      mode,
  input  logic [skek_pkg::CFG_DATA_W-1:0] sf2,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [skek_pkg::KV_W-1:0]       out_tdata,
  output logic [0:0]                      out_tuser
);

  localparam int AW    = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PS    = skek_pkg::POS_SHIFT;
  localparam int POS_W = PS + AW;
  localparam logic [63:0] H =
    (64'(skek_pkg::DIST_RANGE / 2) << 30) / EXP_TABLE_DEPTH;

  typedef logic [32:0] rom_t [EXP_TABLE_DEPTH + 1];

  function automatic logic [63:0] exp_base();
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 30;
    sum  = term;
    for (int n = 1; n <= skek_pkg::TAYLOR_TERMS; n++) begin
      term = ((term * H) >> 30) / 64'(n);
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return (sum << 2) & 64'hFFFF_FFFF;
  endfunction

  localparam logic [63:0] BASE = exp_base();

  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] prev;
    t[0] = 33'h1_0000_0000;
    for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
      prev = 64'(t[k-1]);
      t[k] = 33'((prev * BASE + (64'd1 << 31)) >> 32);
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOOK   = 8'b0000_0010,
    ST_RDA    = 8'b0000_0100,
    ST_RDB    = 8'b0000_1000,
    ST_INTERP = 8'b0001_0000,
    ST_SCALE  = 8'b0010_0000,
    ST_MODE   = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  state_t                    state_r;
  state_t                    state_nxt;
  logic [skek_pkg::ACC_W-1:0] d2_r;
  logic                      ovf_r;
  logic                      big_r;
  logic [AW-1:0]             idx_r;
  logic [PS-1:0]             frac_r;
  logic [32:0]               rom_q_r;
  logic [32:0]               a_r;
  logic [32:0]               ip_r;
  logic [56:0]               pp_r;
  logic [31:0]               val_r;
  logic                      sat_r;

  logic [AW-1:0]             rd_addr;
  logic [POS_W-1:0]          pos;
  logic [32:0]               dab;
  logic [54:0]               ip_prod;
  logic [32:0]               e;
  logic [23:0]               p;
  logic [53:0]               m1;

  assign job_ready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = val_r;
  assign out_tuser  = sat_r;

  always_comb begin
    rd_addr = (state_r == ST_RDA) ? idx_r : idx_r + 1'b1;
    pos     = POS_W'(d2_r[29:8]) * POS_W'(EXP_TABLE_DEPTH);
    dab     = a_r - rom_q_r;
    ip_prod = 55'(dab) * 55'(frac_r);
    e       = big_r ? '0 : a_r - ip_r;
    p       = pp_r[55:32];
    m1      = 54'(p) * 54'(d2_r[29:0]);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (job_valid) state_nxt = ST_LOOK;
      ST_LOOK:   state_nxt = ST_RDA;
      ST_RDA:    state_nxt = ST_RDB;
      ST_RDB:    state_nxt = ST_INTERP;
      ST_INTERP: state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_MODE;
      ST_MODE:   state_nxt = ST_OUT;
      ST_OUT:    if (out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rom_q_r <= ROM[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && job_valid) begin
      d2_r  <= job.d2;
      ovf_r <= job.ovf;
    end
    if (state_r == ST_LOOK) begin
      big_r  <= |d2_r[skek_pkg::ACC_W-1:30];
      idx_r  <= pos[POS_W-1:PS];
      frac_r <= pos[PS-1:0];
    end
    if (state_r == ST_RDB) begin
      a_r <= rom_q_r;
    end
    if (state_r == ST_INTERP) begin
      ip_r <= ip_prod[54:PS];
    end
    if (state_r == ST_SCALE) begin
      pp_r <= 57'(sf2) * 57'(e);
    end
    if (state_r == ST_MODE) begin
      sat_r <= ovf_r;
      unique case (mode)
        skek_pkg::MODE_DLEN:   val_r <= 32'(m1[53:24]);
        skek_pkg::MODE_DSCALE: val_r <= 32'({p, 1'b0});
        default:               val_r <= 32'(p);
      endcase
    end
  end

endmodule

@@ sv/squared_exponential_kernel_top.sv @@
// Top level: one coordinate pair per transaction, one kernel value per closed point pair.
// Throughput: one coordinate transaction per cycle while the queue is not full; a pair close
// busies the finish unit until its result is taken, so it takes no new close before then.
// From the closing transaction to out_tvalid: queue, square, scale, accumulate, then a
// 7-step table lookup and scaling sequencer with one ROM port.
// Reset: synchronous active-low rst_n clears control state and loads config reset values.
`include "assert_macros.svh"
module squared_exponential_kernel_top #(
  parameter int COORD_WIDTH     = skek_pkg::COORD_WIDTH_DEF,
  parameter int EXP_TABLE_DEPTH = skek_pkg::EXP_TABLE_DEPTH_DEF,
  parameter int MAX_DIM         = skek_pkg::MAX_DIM_DEF,
  localparam int IN_TDATA_W     = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_TDATA_W-1:0]           in_tdata,   // first_coord, second_coord
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [skek_pkg::KV_W-1:0]       out_tdata,  // kernel_value
  output logic [0:0]                      out_tuser,  // saturated
  input  logic                            cfg_we,
  input  logic [skek_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [skek_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [1:0]                      mode_r;
  logic [skek_pkg::CFG_DATA_W-1:0] ilsq_r;
  logic [skek_pkg::CFG_DATA_W-1:0] sf2_r;

  logic                   q_full;
  logic                   q_push;
  logic [COORD_WIDTH:0]   q_wdata;
  logic                   q_valid;
  logic                   q_pop_w;
  logic [COORD_WIDTH:0]   q_rdata;
  logic                   job_valid;
  logic                   job_ready;
  skek_pkg::job_t         job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= skek_pkg::MODE_COV;
      ilsq_r <= skek_pkg::ILSQ_RESET;
      sf2_r  <= skek_pkg::SF2_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        skek_pkg::CFG_MODE:    mode_r <= cfg_wdata[1:0];
        skek_pkg::CFG_INV_LSQ: ilsq_r <= cfg_wdata;
        skek_pkg::CFG_SIG_VAR: sf2_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  skek_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .MAX_DIM     (MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .first_coord  (in_tdata[COORD_WIDTH-1:0]),
    .second_coord (in_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .in_tlast     (in_tlast),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  skek_fifo #(
    .W     (COORD_WIDTH + 1),
    .DEPTH (skek_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop_w),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  skek_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop_w),
    .ilsq      (ilsq_r),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  skek_finish #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job),
    .job_ready  (job_ready),
    .mode       (mode_r),
    .sf2        (sf2_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `SKEK_ASSERT_IMPL(a_hold_on_busy_finish, job_valid && !job_ready, !q_pop_w)
  `SKEK_ASSERT_NEXT(a_finish_busy_after_handoff, job_valid && job_ready, !job_ready)
  `SKEK_ASSERT_IMPL(a_saturated_gives_zero, out_tvalid && out_tuser[0], out_tdata == '0)

endmodule
